// ===== rtl/p2f_pkg.sv =====
package p2f_pkg;

	localparam int PAGE_W  = 32;
	localparam int FRAME_W = 16;
	localparam int REQ_W   = 2;
	localparam int STAT_W  = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2
	} req_code_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// one slot of a row as it sits in the row memory
	typedef struct packed {
		logic               valid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} slot_t;

	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] frame_out;
		logic [STAT_W-1:0]  status;
	} rsp_t;

endpackage

// ===== rtl/p2f_if.sv =====
interface p2f_req_if;
	logic                         valid;
	logic                         ready;
	logic [p2f_pkg::REQ_W-1:0]    req_type;
	logic [p2f_pkg::PAGE_W-1:0]   page_id;
	logic [p2f_pkg::FRAME_W-1:0]  frame_in;

	modport source (output valid, req_type, page_id, frame_in, input ready);
	modport sink   (input valid, req_type, page_id, frame_in, output ready);
endinterface

interface p2f_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [p2f_pkg::FRAME_W-1:0]  frame_out;
	logic [p2f_pkg::STAT_W-1:0]   status;

	modport source (output valid, found, frame_out, status, input ready);
	modport sink   (input valid, found, frame_out, status, output ready);
endinterface

// ===== rtl/p2f_row_index.sv =====
module p2f_row_index #(
	parameter int ROW_COUNT = 256,
	parameter int ROW_W     = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [p2f_pkg::PAGE_W-1:0]  page_id,
	output logic                        done,
	output logic [ROW_W-1:0]            row
);
	import p2f_pkg::*;

	localparam bit IS_POW2 = (ROW_COUNT & (ROW_COUNT - 1)) == 0;

	generate
		if (IS_POW2) begin : g_mask
			assign row  = ROW_W'(page_id & PAGE_W'(ROW_COUNT - 1));
			assign done = 1'b1;
		end else begin : g_recip
			// quotient estimate from a truncated reciprocal is exact or one low,
			// so a single compare and subtract finishes the remainder
			localparam int                PROD_W     = 2 * PAGE_W;
			localparam logic [PROD_W-1:0] RECIP_WIDE =
				(PROD_W'(1) << PAGE_W) / PROD_W'(ROW_COUNT);
			localparam logic [PAGE_W-1:0] RECIP      = RECIP_WIDE[PAGE_W-1:0];
			localparam logic [PAGE_W-1:0] DIVISOR    = PAGE_W'(ROW_COUNT);
			localparam logic [ROW_W:0]    DIV_NARROW = (ROW_W+1)'(ROW_COUNT);

			logic [PAGE_W-1:0] x_q;
			logic [PAGE_W-1:0] quot_q;
			logic [ROW_W:0]    rem_q;
			logic [ROW_W-1:0]  row_q;
			logic [1:0]        cnt_q;
			logic              busy_q;
			logic [PROD_W-1:0] prod;
			logic [PAGE_W-1:0] diff;
			logic [ROW_W:0]    reduced;

			always_comb begin
				prod    = PROD_W'(x_q) * PROD_W'(RECIP);
				diff    = x_q - quot_q * DIVISOR;
				reduced = (rem_q >= DIV_NARROW) ? rem_q - DIV_NARROW : rem_q;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= 2'd3;
				end else if (busy_q) begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 2'd1)
						busy_q <= 1'b0;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					x_q <= page_id;
				end else if (busy_q) begin
					quot_q <= prod[PROD_W-1:PAGE_W];
					rem_q  <= diff[ROW_W:0];
					row_q  <= reduced[ROW_W-1:0];
				end
			end

			assign row  = row_q;
			assign done = !busy_q;
		end
	endgenerate

endmodule

// ===== rtl/p2f_row_mem.sv =====
module p2f_row_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 392
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/p2f_row_update.sv =====
module p2f_row_update #(
	parameter int SLOTS = 8
) (
	input  p2f_pkg::slot_t [SLOTS-1:0]   row,
	input  logic [p2f_pkg::REQ_W-1:0]    req_type,
	input  logic [p2f_pkg::PAGE_W-1:0]   page_id,
	input  logic [p2f_pkg::FRAME_W-1:0]  frame_in,
	output p2f_pkg::slot_t [SLOTS-1:0]   new_row,
	output logic                         we,
	output p2f_pkg::rsp_t                result
);
	import p2f_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0]  hit_vec;
	logic [SLOTS-1:0]  empty_vec;
	logic [SLOT_W-1:0] hit_idx;
	logic [SLOT_W-1:0] empty_idx;
	logic              has_hit;
	logic              has_empty;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			hit_vec[s]   = row[s].valid && (row[s].page == page_id);
			empty_vec[s] = !row[s].valid;
		end
	end

	// first hit and first free slot in row order
	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (hit_vec[s])
				hit_idx = SLOT_W'(s);
			if (empty_vec[s])
				empty_idx = SLOT_W'(s);
		end
		has_hit   = |hit_vec;
		has_empty = |empty_vec;
	end

	always_comb begin
		new_row          = row;
		we               = 1'b0;
		result.found     = has_hit;
		result.frame_out = '0;
		result.status    = ST_OK;
		case (req_type)
			REQ_INSERT: begin
				if (has_hit) begin
					new_row[hit_idx].frame = frame_in;
					we = 1'b1;
				end else if (has_empty) begin
					new_row[empty_idx].valid = 1'b1;
					new_row[empty_idx].page  = page_id;
					new_row[empty_idx].frame = frame_in;
					we = 1'b1;
				end else begin
					result.status = ST_FULL;
				end
			end
			REQ_REMOVE: begin
				if (has_hit) begin
					result.frame_out = row[hit_idx].frame;
					new_row[hit_idx].valid = 1'b0;
					we = 1'b1;
				end else begin
					result.status = ST_MISSING;
				end
			end
			default: begin
				// lookup, and the unused code behaves the same
				if (has_hit)
					result.frame_out = row[hit_idx].frame;
				else
					result.status = ST_MISSING;
			end
		endcase
	end

endmodule

// ===== rtl/page_to_frame_hash_map.sv =====
// Page id to buffer frame map, bucketed by row = page_id mod ROW_COUNT.
// Each row holds SLOTS_PER_BLOCK * BLOCKS_PER_ROW slots kept in one wide
// memory word, scanned in row order.
// req channel: req_type (lookup / insert / remove), page_id, frame_in.
// rsp channel: found, frame_out, status; exactly one response per request.
// With ROW_COUNT a power of two a request takes a row read and then the
// compare over all slots with the write back. The next request is taken
// right after the write back; requests never overlap.
// Otherwise the row index comes from a reciprocal-multiply remainder unit,
// and the row read waits until that unit is done.
// The response sits in an output register; while it waits the next request
// is still taken and worked up to its write back, then holds until the
// receiver takes the pending response.
// After reset a clearing pass writes every row empty, one row a cycle;
// req.ready stays low until it ends.
module page_to_frame_hash_map #(
	parameter int ROW_COUNT       = 256,
	parameter int SLOTS_PER_BLOCK = 4,
	parameter int BLOCKS_PER_ROW  = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	p2f_req_if.sink      req,
	p2f_rsp_if.source    rsp
);
	import p2f_pkg::*;

	localparam int  ROW_SLOTS = SLOTS_PER_BLOCK * BLOCKS_PER_ROW;
	localparam int  ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int  ROW_BITS  = ROW_SLOTS * $bits(slot_t);
	localparam bit  IS_POW2   = (ROW_COUNT & (ROW_COUNT - 1)) == 0;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_EXEC
	} state_t;

	state_t                 state_q;
	logic [ROW_W-1:0]       clr_q;
	logic [ROW_W-1:0]       row_q;
	logic [REQ_W-1:0]       req_type_q;
	logic [PAGE_W-1:0]      page_q;
	logic [FRAME_W-1:0]     frame_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                   accept;
	logic                   idx_done;
	logic [ROW_W-1:0]       idx_row;
	logic                   rd_en;
	logic                   wr_en;
	logic [ROW_W-1:0]       wr_addr;
	slot_t [ROW_SLOTS-1:0]  wr_row;
	slot_t [ROW_SLOTS-1:0]  rd_row;
	slot_t [ROW_SLOTS-1:0]  new_row;
	logic                   upd_we;
	rsp_t                   upd_rsp;
	logic                   exec_done;
	logic                   clr_last;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign exec_done = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);
	assign clr_last  = (clr_q == ROW_W'(ROW_COUNT - 1));

	p2f_row_index #(
		.ROW_COUNT (ROW_COUNT),
		.ROW_W     (ROW_W)
	) u_index (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.page_id (req.page_id),
		.done    (idx_done),
		.row     (idx_row)
	);

	assign rd_en = IS_POW2 ? accept : ((state_q == S_HASH) && idx_done);

	always_comb begin
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_row  = '0;
		end else begin
			wr_en   = exec_done && upd_we;
			wr_addr = row_q;
			wr_row  = new_row;
		end
	end

	p2f_row_mem #(
		.DEPTH  (ROW_COUNT),
		.ADDR_W (ROW_W),
		.DATA_W (ROW_BITS)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_row),
		.re    (rd_en),
		.raddr (idx_row),
		.rdata (rd_row)
	);

	p2f_row_update #(
		.SLOTS (ROW_SLOTS)
	) u_update (
		.row      (rd_row),
		.req_type (req_type_q),
		.page_id  (page_q),
		.frame_in (frame_q),
		.new_row  (new_row),
		.we       (upd_we),
		.result   (upd_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec_done)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept)
						state_q <= IS_POW2 ? S_EXEC : S_HASH;
				end
				S_HASH: begin
					if (idx_done)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_done)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			page_q     <= req.page_id;
			frame_q    <= req.frame_in;
		end
		if (rd_en)
			row_q <= idx_row;
		if (exec_done)
			rsp_q <= upd_rsp;
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.found     = rsp_q.found;
	assign rsp.frame_out = rsp_q.frame_out;
	assign rsp.status    = rsp_q.status;

endmodule
